@@ hdl/shist_pkg.sv @@
// ----------------------------------------------------------------------------
// shist_pkg
// Shared types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package shist_pkg;

  localparam int SECTORS_DEF  = 8;
  localparam int MAX_BINS_DEF = 16;

  localparam int POS_W     = 20;
  localparam int CURV_W    = 16;
  localparam int REG_W     = 5;
  localparam int CNT_W     = 16;
  localparam int ANG_W     = 16;
  localparam int CORDIC_W  = 24;
  localparam int ITERS     = 16;
  localparam int ITER_W    = 4;
  localparam int PROD_W    = 40;
  localparam int D2_W      = 41;
  localparam int CURV_SCALE = 10;

  localparam int RADIUS_W  = 19;
  localparam int BCOUNT_W  = 5;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  localparam int S_TDATA_W = 88;
  localparam int M_TDATA_W = 24;

  localparam logic [1:0] REG_SPLIT = 2'd0;
  localparam logic [1:0] REG_OUTER = 2'd1;
  localparam logic [1:0] REG_INNER = 2'd2;
  localparam logic [1:0] REG_BINS  = 2'd3;

  localparam logic [ITER_W-1:0] MUL_X     = 4'd0;
  localparam logic [ITER_W-1:0] MUL_Y     = 4'd1;
  localparam logic [ITER_W-1:0] MUL_Z     = 4'd2;
  localparam logic [ITER_W-1:0] MUL_OUTER = 4'd3;
  localparam logic [ITER_W-1:0] MUL_INNER = 4'd4;

  typedef enum logic [1:0] {
    ADDR_CLEAR,
    ADDR_FRONT,
    ADDR_BACK,
    ADDR_READ
  } addr_sel_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ITER,
    ST_CLASS,
    ST_FRD,
    ST_FWR,
    ST_BRD,
    ST_BWR,
    ST_RRD,
    ST_RWR
  } state_e;

  typedef struct packed {
    logic      capture;
    logic      iter_en;
    logic      classify;
    logic      rd_en;
    logic      wr_en;
    logic      wr_zero;
    addr_sel_e addr_sel;
    logic      out_load;
    logic      out_last;
  } cmd_t;

  typedef struct packed {
    logic keep;
    logic out_free;
  } sts_t;

  function automatic logic [ANG_W-1:0] atan_turn(input logic [ITER_W-1:0] i);
    logic [ANG_W-1:0] v;
    case (i)
      4'd0:    v = 16'd8192;
      4'd1:    v = 16'd4836;
      4'd2:    v = 16'd2555;
      4'd3:    v = 16'd1297;
      4'd4:    v = 16'd651;
      4'd5:    v = 16'd326;
      4'd6:    v = 16'd163;
      4'd7:    v = 16'd81;
      4'd8:    v = 16'd41;
      4'd9:    v = 16'd20;
      4'd10:   v = 16'd10;
      4'd11:   v = 16'd5;
      4'd12:   v = 16'd3;
      4'd13:   v = 16'd1;
      4'd14:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ hdl/spherical_sector_histogram.sv @@
// ----------------------------------------------------------------------------
// spherical_sector_histogram
// Azimuth sector, shell, half and curvature binning of points into histograms, with region readout.
// ----------------------------------------------------------------------------
// After reset the store is cleared, all 2*4*SECTORS*MAX_BINS entries (1024 by
// default), and no item is accepted until that pass ends. An add-point item
// is accepted, runs 16 iterations of the shared CORDIC unit, is classified and
// does a read-modify-write of the front and back counts on the single store
// port in four steps; a dropped item returns to idle at the first step without
// writing. A read item takes one store read and one store write per bin in
// use, and waits while the result register is held by the consumer.
`default_nettype none

module spherical_sector_histogram #(
  parameter int SECTORS  = shist_pkg::SECTORS_DEF,
  parameter int MAX_BINS = shist_pkg::MAX_BINS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // pos_x[19:0], pos_y[39:20], pos_z[59:40], curv[75:60], read_set[76],
  // read_region[81:77], zero fill
  input  wire [shist_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // mode[0]
  input  wire                              s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // bin_index[3:0], bin_total[19:4], zero fill
  output logic [shist_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tlast,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [shist_pkg::APB_AW-1:0]      paddr,
  input  wire [shist_pkg::APB_DW-1:0]      pwdata,
  output logic [shist_pkg::APB_DW-1:0]     prdata,
  output logic                             pready
);

  localparam int REGIONS = 4 * SECTORS;
  localparam int DEPTH   = 2 * REGIONS * MAX_BINS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int NB_W    = $clog2(MAX_BINS + 1);

  logic [shist_pkg::ANG_W-1:0]    split_q;
  logic [shist_pkg::RADIUS_W-1:0] outer_q, inner_q;
  logic [shist_pkg::BCOUNT_W-1:0] bins_q;
  logic [NB_W-1:0]                nb;
  logic                           wr;
  logic [1:0]                     idx;

  shist_pkg::cmd_t                cmd;
  shist_pkg::sts_t                sts;
  logic [shist_pkg::ITER_W-1:0]   iter;
  logic [NB_W-1:0]                bin;
  logic [ADDR_W-1:0]              clr_addr;
  logic [3:0]                     out_index;
  logic [shist_pkg::CNT_W-1:0]    out_total;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_q <= '0;
      outer_q <= 19'd15360;
      inner_q <= 19'd5120;
      bins_q  <= 5'd11;
    end else if (wr) begin
      case (idx)
        shist_pkg::REG_SPLIT: split_q <= pwdata[shist_pkg::ANG_W-1:0];
        shist_pkg::REG_OUTER: outer_q <= pwdata[shist_pkg::RADIUS_W-1:0];
        shist_pkg::REG_INNER: inner_q <= pwdata[shist_pkg::RADIUS_W-1:0];
        shist_pkg::REG_BINS:  bins_q  <= pwdata[shist_pkg::BCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      shist_pkg::REG_SPLIT: prdata = 32'(split_q);
      shist_pkg::REG_OUTER: prdata = 32'(outer_q);
      shist_pkg::REG_INNER: prdata = 32'(inner_q);
      shist_pkg::REG_BINS:  prdata = 32'(bins_q);
      default:              prdata = '0;
    endcase
  end

  assign nb = (int'(bins_q) < MAX_BINS) ? NB_W'(bins_q) : NB_W'(MAX_BINS);

  shist_ctrl #(
    .SECTORS (SECTORS),
    .MAX_BINS(MAX_BINS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_mode_i (s_axis_tuser),
    .nb_i      (nb),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .iter_o    (iter),
    .bin_o     (bin),
    .clr_addr_o(clr_addr)
  );

  shist_datapath #(
    .SECTORS (SECTORS),
    .MAX_BINS(MAX_BINS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .iter_i        (iter),
    .bin_i         (bin),
    .clr_addr_i    (clr_addr),
    .sts_o         (sts),
    .pos_x_i       ($signed(s_axis_tdata[19:0])),
    .pos_y_i       ($signed(s_axis_tdata[39:20])),
    .pos_z_i       ($signed(s_axis_tdata[59:40])),
    .curv_i        (s_axis_tdata[75:60]),
    .read_set_i    (s_axis_tdata[76]),
    .read_region_i (s_axis_tdata[81:77]),
    .split_angle_i (split_q),
    .outer_radius_i(outer_q),
    .inner_radius_i(inner_q),
    .nb_i          (nb),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_index_o   (out_index),
    .out_total_o   (out_total),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, out_total, out_index};

endmodule

`default_nettype wire

@@ hdl/shist_datapath.sv @@
// ----------------------------------------------------------------------------
// shist_datapath
// CORDIC angle, squared distances, binning, histogram store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module shist_datapath #(
  parameter int SECTORS  = shist_pkg::SECTORS_DEF,
  parameter int MAX_BINS = shist_pkg::MAX_BINS_DEF,
  localparam int REGIONS = 4 * SECTORS,
  localparam int DEPTH   = 2 * REGIONS * MAX_BINS,
  localparam int ADDR_W  = $clog2(DEPTH),
  localparam int NB_W    = $clog2(MAX_BINS + 1)
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire shist_pkg::cmd_t                  cmd_i,
  input  wire [shist_pkg::ITER_W-1:0]           iter_i,
  input  wire [NB_W-1:0]                        bin_i,
  input  wire [ADDR_W-1:0]                      clr_addr_i,
  output shist_pkg::sts_t                       sts_o,
  input  wire signed [shist_pkg::POS_W-1:0]     pos_x_i,
  input  wire signed [shist_pkg::POS_W-1:0]     pos_y_i,
  input  wire signed [shist_pkg::POS_W-1:0]     pos_z_i,
  input  wire [shist_pkg::CURV_W-1:0]           curv_i,
  input  wire                                   read_set_i,
  input  wire [shist_pkg::REG_W-1:0]            read_region_i,
  input  wire [shist_pkg::ANG_W-1:0]            split_angle_i,
  input  wire [shist_pkg::RADIUS_W-1:0]         outer_radius_i,
  input  wire [shist_pkg::RADIUS_W-1:0]         inner_radius_i,
  input  wire [NB_W-1:0]                        nb_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic [3:0]                            out_index_o,
  output logic [shist_pkg::CNT_W-1:0]           out_total_o,
  output logic                                  out_last_o
);

  localparam int CW = shist_pkg::CORDIC_W;

  logic signed [shist_pkg::POS_W-1:0] px_q, py_q, pz_q;
  logic [shist_pkg::CURV_W-1:0]       curv_q;
  logic                               set_q;
  logic [shist_pkg::REG_W-1:0]        region_q;
  logic signed [CW-1:0]               cx_q, cy_q;
  logic [shist_pkg::ANG_W-1:0]        cz_q;
  logic                               origin_q;
  logic signed [shist_pkg::PROD_W-1:0] prod_q;
  logic [shist_pkg::ITER_W-1:0]       tag_q;
  logic                               mul_vld_q;
  logic [shist_pkg::D2_W-1:0]         d2_q, ro_q, ri_q;
  logic                               keep_q;
  logic [ADDR_W-1:0]                  addr_f_q, addr_b_q;
  logic [shist_pkg::CNT_W-1:0]        mem [DEPTH];
  logic [shist_pkg::CNT_W-1:0]        rdata_q;
  logic                               out_valid_q;
  logic [3:0]                         out_index_q;
  logic [shist_pkg::CNT_W-1:0]        out_total_q;
  logic                               out_last_q;

  logic signed [CW-1:0]               x0, y0, dx, dy, sx, sy;
  logic signed [shist_pkg::POS_W-1:0] mul_op;
  logic [shist_pkg::ANG_W-1:0]        ang, rel_f, rel_b;
  logic [3:0]                         cbin;
  logic [19:0]                        cprod;
  logic                               keep_d, shell, half, region_ok;
  logic [ADDR_W-1:0]                  addr_f_d, addr_b_d, addr_rd, addr;
  logic [shist_pkg::CNT_W-1:0]        wdata;
  int                                 sec_f, sec_b, reg_f, reg_b, rd_idx;

  assign x0 = CW'(px_q);
  assign y0 = CW'(py_q);
  assign sx = (px_q < 0) ? -x0 : x0;
  assign sy = (px_q < 0) ? -y0 : y0;
  assign dx = cy_q >>> iter_i;
  assign dy = cx_q >>> iter_i;

  always_comb begin
    case (iter_i)
      shist_pkg::MUL_X:     mul_op = px_q;
      shist_pkg::MUL_Y:     mul_op = py_q;
      shist_pkg::MUL_Z:     mul_op = pz_q;
      shist_pkg::MUL_OUTER: mul_op = $signed({1'b0, outer_radius_i});
      default:              mul_op = $signed({1'b0, inner_radius_i});
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      px_q     <= pos_x_i;
      py_q     <= pos_y_i;
      pz_q     <= pos_z_i;
      curv_q   <= curv_i;
      set_q    <= read_set_i;
      region_q <= read_region_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      tag_q     <= '0;
    end else begin
      mul_vld_q <= cmd_i.iter_en && (iter_i <= shist_pkg::MUL_INNER);
      tag_q     <= iter_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_op * mul_op;
    if (cmd_i.capture) begin
      d2_q <= '0;
    end else if (mul_vld_q) begin
      case (tag_q)
        shist_pkg::MUL_OUTER: ro_q <= shist_pkg::D2_W'(prod_q);
        shist_pkg::MUL_INNER: ri_q <= shist_pkg::D2_W'(prod_q);
        default:              d2_q <= d2_q + shist_pkg::D2_W'(prod_q);
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.iter_en && iter_i == '0) begin
      origin_q <= (px_q == '0) && (py_q == '0);
    end
    if (cmd_i.iter_en) begin
      if (iter_i == '0) begin
        if (sy > 0) begin
          cx_q <= sx + sy;
          cy_q <= sy - sx;
          cz_q <= ((px_q < 0) ? 16'h8000 : 16'h0000) + shist_pkg::atan_turn(iter_i);
        end else begin
          cx_q <= sx - sy;
          cy_q <= sy + sx;
          cz_q <= ((px_q < 0) ? 16'h8000 : 16'h0000) - shist_pkg::atan_turn(iter_i);
        end
      end else if (cy_q > 0) begin
        cx_q <= cx_q + dx;
        cy_q <= cy_q - dy;
        cz_q <= cz_q + shist_pkg::atan_turn(iter_i);
      end else begin
        cx_q <= cx_q - dx;
        cy_q <= cy_q + dy;
        cz_q <= cz_q - shist_pkg::atan_turn(iter_i);
      end
    end
  end

  assign ang   = origin_q ? '0 : cz_q;
  assign rel_f = ang - split_angle_i;
  assign rel_b = rel_f + 16'h8000;
  assign cprod = 20'(curv_q) * 20'(shist_pkg::CURV_SCALE);
  assign cbin  = cprod[19:16];
  assign shell = !(d2_q <= ri_q);
  assign half  = pz_q < 0;

  always_comb begin
    sec_f    = (int'(rel_f) * SECTORS) >>> 16;
    sec_b    = (int'(rel_b) * SECTORS) >>> 16;
    reg_f    = sec_f + SECTORS * (int'(half) + 2 * int'(shell));
    reg_b    = sec_b + SECTORS * (int'(half) + 2 * int'(shell));
    addr_f_d = ADDR_W'(reg_f * MAX_BINS + int'(cbin));
    addr_b_d = ADDR_W'((REGIONS + reg_b) * MAX_BINS + int'(cbin));
    keep_d   = (d2_q < ro_q) && (int'(cbin) < int'(nb_i));
    rd_idx   = (int'(set_q) * REGIONS + int'(region_q)) * MAX_BINS + int'(bin_i);
    addr_rd  = ADDR_W'(rd_idx);
  end

  assign region_ok = int'(region_q) < REGIONS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= 1'b0;
    end else if (cmd_i.classify) begin
      keep_q <= keep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.classify) begin
      addr_f_q <= addr_f_d;
      addr_b_q <= addr_b_d;
    end
  end

  always_comb begin
    case (cmd_i.addr_sel)
      shist_pkg::ADDR_CLEAR: addr = clr_addr_i;
      shist_pkg::ADDR_FRONT: addr = addr_f_q;
      shist_pkg::ADDR_BACK:  addr = addr_b_q;
      default:               addr = addr_rd;
    endcase
  end

  assign wdata = cmd_i.wr_zero ? '0 :
                 (rdata_q == '1) ? rdata_q : rdata_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && (cmd_i.addr_sel != shist_pkg::ADDR_READ || region_ok)) begin
      mem[addr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_index_q <= 4'(bin_i);
      out_total_q <= region_ok ? rdata_q : '0;
      out_last_q  <= cmd_i.out_last;
    end
  end

  assign sts_o.keep     = keep_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_index_o    = out_index_q;
  assign out_total_o    = out_total_q;
  assign out_last_o     = out_last_q;

endmodule

`default_nettype wire

@@ hdl/shist_ctrl.sv @@
// ----------------------------------------------------------------------------
// shist_ctrl
// Sequencer for store clearing, point binning and region readout.
// ----------------------------------------------------------------------------
`default_nettype none

module shist_ctrl #(
  parameter int SECTORS  = shist_pkg::SECTORS_DEF,
  parameter int MAX_BINS = shist_pkg::MAX_BINS_DEF,
  localparam int REGIONS = 4 * SECTORS,
  localparam int DEPTH   = 2 * REGIONS * MAX_BINS,
  localparam int ADDR_W  = $clog2(DEPTH),
  localparam int NB_W    = $clog2(MAX_BINS + 1)
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire                         in_mode_i,
  input  wire [NB_W-1:0]              nb_i,
  input  wire shist_pkg::sts_t        sts_i,
  output shist_pkg::cmd_t             cmd_o,
  output logic [shist_pkg::ITER_W-1:0] iter_o,
  output logic [NB_W-1:0]             bin_o,
  output logic [ADDR_W-1:0]           clr_addr_o
);

  shist_pkg::state_e state_q, state_d;
  logic [shist_pkg::ITER_W-1:0] iter_q, iter_d;
  logic [NB_W-1:0]              bin_q, bin_d;
  logic [ADDR_W-1:0]            clr_q, clr_d;
  logic                         accept, last;

  assign in_ready_o = (state_q == shist_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign last       = (NB_W'(bin_q + 1'b1) == nb_i);

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    bin_d   = bin_q;
    clr_d   = clr_q;
    case (state_q)
      shist_pkg::ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (int'(clr_q) == DEPTH - 1) state_d = shist_pkg::ST_IDLE;
      end
      shist_pkg::ST_IDLE: begin
        iter_d = '0;
        bin_d  = '0;
        if (accept) begin
          if (!in_mode_i)          state_d = shist_pkg::ST_ITER;
          else if (nb_i != '0)     state_d = shist_pkg::ST_RRD;
        end
      end
      shist_pkg::ST_ITER: begin
        iter_d = iter_q + 1'b1;
        if (iter_q == shist_pkg::ITER_W'(shist_pkg::ITERS - 1)) state_d = shist_pkg::ST_CLASS;
      end
      shist_pkg::ST_CLASS: state_d = shist_pkg::ST_FRD;
      shist_pkg::ST_FRD:   state_d = sts_i.keep ? shist_pkg::ST_FWR : shist_pkg::ST_IDLE;
      shist_pkg::ST_FWR:   state_d = shist_pkg::ST_BRD;
      shist_pkg::ST_BRD:   state_d = shist_pkg::ST_BWR;
      shist_pkg::ST_BWR:   state_d = shist_pkg::ST_IDLE;
      shist_pkg::ST_RRD:   state_d = shist_pkg::ST_RWR;
      shist_pkg::ST_RWR: begin
        if (sts_i.out_free) begin
          bin_d   = bin_q + 1'b1;
          state_d = last ? shist_pkg::ST_IDLE : shist_pkg::ST_RRD;
        end
      end
      default: state_d = shist_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.addr_sel = shist_pkg::ADDR_READ;
    case (state_q)
      shist_pkg::ST_CLEAR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_zero  = 1'b1;
        cmd_o.addr_sel = shist_pkg::ADDR_CLEAR;
      end
      shist_pkg::ST_IDLE:  cmd_o.capture  = accept;
      shist_pkg::ST_ITER:  cmd_o.iter_en  = 1'b1;
      shist_pkg::ST_CLASS: cmd_o.classify = 1'b1;
      shist_pkg::ST_FRD: begin
        cmd_o.rd_en    = sts_i.keep;
        cmd_o.addr_sel = shist_pkg::ADDR_FRONT;
      end
      shist_pkg::ST_FWR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.addr_sel = shist_pkg::ADDR_FRONT;
      end
      shist_pkg::ST_BRD: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = shist_pkg::ADDR_BACK;
      end
      shist_pkg::ST_BWR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.addr_sel = shist_pkg::ADDR_BACK;
      end
      shist_pkg::ST_RRD:   cmd_o.rd_en = 1'b1;
      shist_pkg::ST_RWR: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_last = last;
        cmd_o.wr_en    = sts_i.out_free;
        cmd_o.wr_zero  = 1'b1;
      end
      default: cmd_o.addr_sel = shist_pkg::ADDR_READ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= shist_pkg::ST_CLEAR;
      iter_q  <= '0;
      bin_q   <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      bin_q   <= bin_d;
      clr_q   <= clr_d;
    end
  end

  assign iter_o     = iter_q;
  assign bin_o      = bin_q;
  assign clr_addr_o = clr_q;

  a_fwr_after_frd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == shist_pkg::ST_FWR |-> $past(state_q) == shist_pkg::ST_FRD)
    else $error("front write without front read");

  a_bwr_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == shist_pkg::ST_BWR |=> state_q == shist_pkg::ST_IDLE)
    else $error("back write not followed by idle");

  a_bin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == shist_pkg::ST_RRD |-> bin_q < nb_i)
    else $error("readout bin beyond bins in use");

endmodule

`default_nettype wire
